@@ design/mf3_pkg.sv @@
// Shared types, constants and compare helpers of the 3x3 median filter.
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT) + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);
    localparam logic [DIM_W-1:0] LIMIT_WIDTH  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] LIMIT_HEIGHT = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_pix_out;

    // Position flags of one step, decided when the item is accepted.
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_tag;

    // One new window column: two stored rows and the incoming pixel.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    typedef struct packed {
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] md;
        logic [PIX_W-1:0] lo;
    } t_sorted;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < MIN_DIM) r = MIN_DIM;
        else if (v > hi) r = hi;
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_sorted sort3(input t_column c);
        t_sorted s;
        s.hi = max3(c.top, c.mid, c.bot);
        s.lo = min3(c.top, c.mid, c.bot);
        s.md = med3(c.top, c.mid, c.bot);
        return s;
    endfunction

endpackage

@@ design/mf3_ctrl.sv @@
// Frame geometry registers and raster position counters of the median filter.
module mf3_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mf3_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    output logic [mf3_pkg::COL_W-1:0]     o_col,
    output mf3_pkg::t_tag                 o_tag
);

    localparam int DW = mf3_pkg::DIM_W;
    localparam int CW = mf3_pkg::COL_W;
    localparam int RW = mf3_pkg::ROW_W;

    logic [DW-1:0] r_w, r_h;
    logic [CW-1:0] r_in_col, r_out_col, n_in_col, n_out_col;
    logic [RW-1:0] r_in_row, r_out_row, n_in_row, n_out_row;

    logic          in_wrap, out_wrap, emit, interior, last;
    logic [CW-1:0] c0, oc0;
    logic [RW-1:0] row0, or0;
    logic [DW-1:0] c0_inc, oc0_inc, oc0_p2;
    logic [RW:0]   or0_p1, or0_p2, h_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= mf3_pkg::RESET_WIDTH;
            r_h <= mf3_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mf3_pkg::REG_WIDTH:  r_w <= mf3_pkg::clamp_dim(i_cfg_data,
                                                               mf3_pkg::LIMIT_WIDTH);
                mf3_pkg::REG_HEIGHT: r_h <= mf3_pkg::clamp_dim(i_cfg_data,
                                                               mf3_pkg::LIMIT_HEIGHT);
                default: ;
            endcase
        end
    end

    always_comb begin
        // Wrap a column that a narrower width left behind.
        in_wrap  = DW'(r_in_col) >= r_w;
        c0       = in_wrap ? '0 : r_in_col;
        row0     = in_wrap ? r_in_row + RW'(1) : r_in_row;
        c0_inc   = DW'(c0) + DW'(1);
        emit     = (row0 >= RW'(2)) || ((row0 == RW'(1)) && (c0 != '0));

        out_wrap = DW'(r_out_col) >= r_w;
        oc0      = out_wrap ? '0 : r_out_col;
        or0      = out_wrap ? r_out_row + RW'(1) : r_out_row;
        oc0_inc  = DW'(oc0) + DW'(1);
        oc0_p2   = DW'(oc0) + DW'(2);
        or0_p1   = (RW+1)'(or0) + (RW+1)'(1);
        or0_p2   = (RW+1)'(or0) + (RW+1)'(2);
        h_ext    = (RW+1)'(r_h);
        interior = (or0 != '0) && (or0_p2 <= h_ext) && (oc0 != '0) && (oc0_p2 <= r_w);
        last     = (or0_p1 >= h_ext) && (oc0_inc >= r_w);

        if (c0_inc >= r_w) begin
            n_in_col = '0;
            n_in_row = row0 + RW'(1);
        end else begin
            n_in_col = c0_inc[CW-1:0];
            n_in_row = row0;
        end
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (oc0_inc >= r_w) begin
                n_out_col = '0;
                n_out_row = or0 + RW'(1);
            end else begin
                n_out_col = oc0_inc[CW-1:0];
                n_out_row = or0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_col          = c0;
    assign o_tag.emit     = emit;
    assign o_tag.interior = interior;
    assign o_tag.last     = last;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && emit && last) |=> (r_in_col == '0 && r_in_row == '0 &&
                                        r_out_col == '0 && r_out_row == '0))
        else $error("counters not cleared after the last pixel of a frame");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !emit) |=> ($stable(r_out_col) && $stable(r_out_row)))
        else $error("output position moved on a step without a result");

endmodule

@@ design/mf3_line_store.sv @@
// Two-row line store: one read-modify-write memory, each entry holds a column of two rows.
module mf3_line_store (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [mf3_pkg::COL_W-1:0] i_rd_col,
    input  logic                      i_wr_en,
    input  logic [mf3_pkg::COL_W-1:0] i_wr_col,
    input  logic [mf3_pkg::PIX_W-1:0] i_px,
    output mf3_pkg::t_column          o_column
);

    localparam int PW = mf3_pkg::PIX_W;

    logic [2*PW-1:0] mem [mf3_pkg::MAX_WIDTH];
    logic [2*PW-1:0] r_q;
    logic [2*PW-1:0] wr_data;

    // Older row drops out, middle row moves up, new pixel becomes the middle row.
    assign wr_data = {r_q[PW-1:0], i_px};

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_col] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_col == i_rd_col)) begin
                r_q <= wr_data;
            end else begin
                r_q <= mem[i_rd_col];
            end
        end
    end

    assign o_column.top = r_q[2*PW-1:PW];
    assign o_column.mid = r_q[PW-1:0];
    assign o_column.bot = i_px;

endmodule

@@ design/mf3_median.sv @@
// Sliding 3x3 window of sorted columns, two-stage median select and output register.
module mf3_median (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mf3_pkg::t_column  i_column,
    input  mf3_pkg::t_tag     i_tag,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mf3_pkg::t_pix_out o_out_item
);

    localparam int PW = mf3_pkg::PIX_W;

    logic [PW-1:0] r_lo [3];
    logic [PW-1:0] r_md [3];
    logic [PW-1:0] r_hi [3];
    logic [PW-1:0] r_cm1, r_cm2;

    logic          r2_v, r2_interior, r2_last;
    logic          r3_v, r3_interior, r3_last;
    logic [PW-1:0] r3_maxlo, r3_medmd, r3_minhi, r3_center;
    logic          r_ov;
    mf3_pkg::t_pix_out r_out_item;

    logic             en3, en4, take;
    mf3_pkg::t_sorted s_new;

    assign en4     = !r_ov || i_out_ready;
    assign en3     = !r3_v || en4;
    assign o_ready = !r2_v || en3;
    assign take    = i_valid && o_ready;
    assign s_new   = mf3_pkg::sort3(i_column);

    // Shift window on every step, with or without a result.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_lo[0] <= r_lo[1];
            r_lo[1] <= r_lo[2];
            r_lo[2] <= s_new.lo;
            r_md[0] <= r_md[1];
            r_md[1] <= r_md[2];
            r_md[2] <= s_new.md;
            r_hi[0] <= r_hi[1];
            r_hi[1] <= r_hi[2];
            r_hi[2] <= s_new.hi;
            r_cm1   <= r_cm2;
            r_cm2   <= i_column.mid;
            r2_interior <= i_tag.interior;
            r2_last     <= i_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_v) begin
            r3_maxlo    <= mf3_pkg::max3(r_lo[0], r_lo[1], r_lo[2]);
            r3_medmd    <= mf3_pkg::med3(r_md[0], r_md[1], r_md[2]);
            r3_minhi    <= mf3_pkg::min3(r_hi[0], r_hi[1], r_hi[2]);
            r3_center   <= r_cm1;
            r3_interior <= r2_interior;
            r3_last     <= r2_last;
        end
        if (en4 && r3_v) begin
            r_out_item.pixel_out <= r3_interior ?
                                    mf3_pkg::med3(r3_maxlo, r3_medmd, r3_minhi) : r3_center;
            r_out_item.frame_end <= r3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_ready) r2_v <= i_valid && i_tag.emit;
            if (en3)     r3_v <= r2_v;
            if (en4)     r_ov <= r3_v;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out_item;

endmodule

@@ design/median_filter_3x3.sv @@
// Top level of the streaming 3x3 median filter.
//
// Usage: feed an 8-bit grayscale frame in raster order on the input channel
// (i_in_valid / o_in_ready / i_in_item), one pixel per item. Results leave in
// raster order on the output channel (o_out_valid / i_out_ready / o_out_item).
// Interior pixels come out as the median of their 3x3 neighborhood; the
// border rows and columns are copied. Output lags input by width+1 items, so
// after each frame send width+1 drain items (operation = 1) to flush it;
// frame_end marks the last pixel. Frame size is set through the write port
// (i_cfg_we / i_cfg_index / i_cfg_data) while the block is idle; values are
// clamped to 3..1024.
// Throughput: one item per clock while o_in_ready stays high. A result is
// built from registers in order once the item that completes it is accepted:
// the accepting edge registers the line store read, then the window shift and
// column sort, then the median select and the output register. The line
// store is one single-port-write, single-port-read memory touched once per
// item, which sets the one-item-per-cycle figure.
// Reset: counters and pipeline clear, size returns to 640 x 480; the line
// store is not cleared and needs no pass. When the receiver stalls, the
// pipeline keeps filling its empty stages and drops o_in_ready once full.
module median_filter_3x3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mf3_pkg::t_pix_in              i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mf3_pkg::t_pix_out             o_out_item,
    input  logic                          i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mf3_pkg::DIM_W-1:0]     i_cfg_data
);

    logic                      accept;
    logic                      med_ready;
    logic [mf3_pkg::COL_W-1:0] col;
    mf3_pkg::t_tag             tag;
    mf3_pkg::t_column          column;
    logic [mf3_pkg::PIX_W-1:0] px;

    // Read stage: item waits here while its line store entry is fetched.
    logic                      r1_v;
    logic [mf3_pkg::COL_W-1:0] r1_col;
    logic [mf3_pkg::PIX_W-1:0] r1_px;
    mf3_pkg::t_tag             r1_tag;

    assign o_in_ready = !r1_v || med_ready;
    assign accept     = i_in_valid && o_in_ready;

    // A drain step enters the window as a zero pixel.
    assign px = (i_in_item.operation == mf3_pkg::OP_DRAIN) ? '0 : i_in_item.pixel_in;

    mf3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_col       (col),
        .o_tag       (tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (o_in_ready) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_col <= col;
            r1_px  <= px;
            r1_tag <= tag;
        end
    end

    // Write back the shifted column as the item leaves the read stage.
    mf3_line_store u_line_store (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_col (col),
        .i_wr_en  (r1_v && med_ready),
        .i_wr_col (r1_col),
        .i_px     (r1_px),
        .o_column (column)
    );

    mf3_median u_median (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r1_v),
        .o_ready     (med_ready),
        .i_column    (column),
        .i_tag       (r1_tag),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    a_read_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && !med_ready) |=> (r1_v && $stable(r1_col) && $stable(r1_px)))
        else $error("read stage item lost or changed while blocked");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r1_v)
        else $error("input blocked with an empty read stage");

endmodule
